@@ rtl/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// shared types, widths and codes of the speed limiter with pi torque reduction
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int TORQUE_W   = 16;
  localparam int SPEED_W    = 15;
  localparam int PEDAL_W    = 12;
  localparam int INTEG_W    = 24;
  localparam int IMAX_W     = 23;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 16;
  localparam int PPROD_W    = 32;
  localparam int IPROD_W    = 40;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [ACTION_W-1:0] ACT_DISABLED = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_OVER     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HILL     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NORMAL   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PGAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IGAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HILL_THR = 3'd6;

  typedef struct packed {
    logic                       limiting_enabled;
    logic [SPEED_W-1:0]         speed_ceiling;
    logic [IMAX_W-1:0]          integral_max;
    logic signed [INTEG_W-1:0]  integral_min;
    logic [GAIN_W-1:0]          prop_gain;
    logic [GAIN_W-1:0]          integ_gain;
    logic [PEDAL_W-1:0]         hill_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [TORQUE_W-1:0] base;
    logic signed [PPROD_W-1:0]  prop_prod;
    logic signed [IPROD_W-1:0]  integ_prod;
    logic [ACTION_W-1:0]        action;
  } prod_t;

endpackage

@@ rtl/spl_cfg.sv @@
// ----------------------------------------------------------------------------
// spl_cfg
// configuration register file, one register written per word
// ----------------------------------------------------------------------------
module spl_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output spl_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limiting_enabled <= 1'b0;
      cfg.speed_ceiling    <= '1;
      cfg.integral_max     <= '0;
      cfg.integral_min     <= '0;
      cfg.prop_gain        <= '0;
      cfg.integ_gain       <= '0;
      cfg.hill_threshold   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spl_pkg::CFG_ENABLE:   cfg.limiting_enabled <= cfg_data[0];
        spl_pkg::CFG_CEILING:  cfg.speed_ceiling    <= cfg_data[spl_pkg::SPEED_W-1:0];
        spl_pkg::CFG_IMAX:     cfg.integral_max     <= cfg_data[spl_pkg::IMAX_W-1:0];
        spl_pkg::CFG_IMIN:     cfg.integral_min     <= signed'(cfg_data[spl_pkg::INTEG_W-1:0]);
        spl_pkg::CFG_PGAIN:    cfg.prop_gain        <= cfg_data[spl_pkg::GAIN_W-1:0];
        spl_pkg::CFG_IGAIN:    cfg.integ_gain       <= cfg_data[spl_pkg::GAIN_W-1:0];
        spl_pkg::CFG_HILL_THR: cfg.hill_threshold   <= cfg_data[spl_pkg::PEDAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/spl_integ.sv @@
// ----------------------------------------------------------------------------
// spl_integ
// mode decision, integral error update with clamps, and gain products
// ----------------------------------------------------------------------------
module spl_integ (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  spl_pkg::cfg_t                       cfg,
  input  logic signed [spl_pkg::TORQUE_W-1:0] base,
  input  logic [spl_pkg::SPEED_W-1:0]         speed,
  input  logic [spl_pkg::PEDAL_W-1:0]         pedal,
  output spl_pkg::prod_t                      prod,
  output logic signed [spl_pkg::INTEG_W-1:0]  integral
);

  localparam int ACC_W = spl_pkg::INTEG_W + 1;
  localparam int PP_W  = spl_pkg::PPROD_W;
  localparam int IP_W  = spl_pkg::IPROD_W;

  logic signed [spl_pkg::ERR_W-1:0]   err;
  logic                               over;
  logic                               hill;
  logic signed [ACC_W-1:0]            acc;
  logic signed [ACC_W-1:0]            acc_clamp;
  logic signed [spl_pkg::INTEG_W-1:0] integral_next;
  logic [spl_pkg::ACTION_W-1:0]       action_next;
  logic signed [spl_pkg::PPROD_W-1:0] prop_next;
  logic signed [spl_pkg::IPROD_W-1:0] integ_next;

  function automatic logic signed [spl_pkg::INTEG_W-1:0] sat24(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [spl_pkg::INTEG_W-1:0] r;
    if (v[ACC_W-1] != v[ACC_W-2]) begin
      r = v[ACC_W-1] ? {1'b1, {(spl_pkg::INTEG_W-1){1'b0}}}
                     : {1'b0, {(spl_pkg::INTEG_W-1){1'b1}}};
    end else begin
      r = v[spl_pkg::INTEG_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    err  = signed'({1'b0, speed}) - signed'({1'b0, cfg.speed_ceiling});
    over = !err[spl_pkg::ERR_W-1] && (err != '0);
    hill = (pedal > cfg.hill_threshold) && err[spl_pkg::ERR_W-1];
    acc  = ACC_W'(integral) + ACC_W'(err);
    acc_clamp = acc;
    integral_next = '0;
    action_next   = spl_pkg::ACT_NORMAL;
    if (!cfg.limiting_enabled) begin
      action_next = spl_pkg::ACT_DISABLED;
    end else if (over) begin
      if (acc > signed'({2'b00, cfg.integral_max})) begin
        acc_clamp = signed'({2'b00, cfg.integral_max});
      end
      integral_next = sat24(acc_clamp);
      action_next   = spl_pkg::ACT_OVER;
    end else if (hill) begin
      if (acc < ACC_W'(cfg.integral_min)) begin
        acc_clamp = ACC_W'(cfg.integral_min);
      end
      integral_next = sat24(acc_clamp);
      action_next   = spl_pkg::ACT_HILL;
    end
    prop_next  = '0;
    if (action_next == spl_pkg::ACT_OVER) begin
      prop_next = PP_W'(err) * PP_W'(signed'({1'b0, cfg.prop_gain}));
    end
    integ_next = IP_W'(integral_next) * IP_W'(signed'({1'b0, cfg.integ_gain}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (en) begin
      integral <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.base       <= base;
      prod.prop_prod  <= prop_next;
      prod.integ_prod <= integ_next;
      prod.action     <= action_next;
    end
  end

endmodule

@@ rtl/spl_reduce.sv @@
// ----------------------------------------------------------------------------
// spl_reduce
// scales the pi sum; on over or hill subtracts it from torque, saturates
// ----------------------------------------------------------------------------
module spl_reduce (
  input  logic                                clk,
  input  logic                                en,
  input  spl_pkg::prod_t                      prod,
  output logic signed [spl_pkg::TORQUE_W-1:0] torque_out,
  output logic [spl_pkg::ACTION_W-1:0]        action
);

  localparam int SUM_W  = spl_pkg::IPROD_W + 1;
  localparam int RED_W  = SUM_W - 8;
  localparam int DIFF_W = RED_W + 1;

  logic signed [SUM_W-1:0]             sum;
  logic signed [SUM_W-1:0]             biased;
  logic signed [RED_W-1:0]             red;
  logic signed [DIFF_W-1:0]            diff;
  logic signed [spl_pkg::TORQUE_W-1:0] torque_next;

  always_comb begin
    sum    = SUM_W'(prod.prop_prod) + SUM_W'(prod.integ_prod);
    // round toward zero on the divide by 256
    biased = sum + (sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
    red    = RED_W'(biased >>> 8);
    diff   = DIFF_W'(prod.base) - DIFF_W'(red);
    torque_next = prod.base;
    if ((prod.action == spl_pkg::ACT_OVER) || (prod.action == spl_pkg::ACT_HILL)) begin
      if (diff[DIFF_W-1]) begin
        torque_next = '0;
      end else if (diff > DIFF_W'(32767)) begin
        torque_next = {1'b0, {(spl_pkg::TORQUE_W-1){1'b1}}};
      end else begin
        torque_next = diff[spl_pkg::TORQUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      torque_out <= torque_next;
      action     <= prod.action;
    end
  end

endmodule

@@ rtl/speed_limiter_pi_torque.sv @@
// Speed limiter with pi torque reduction. One word is taken per clock cycle
// unless in_stall is high, and one result word leaves per word taken, in
// order; a word passes to the output through three registers: input
// register (loaded at the accepting edge), product register (integral update
// and both gain multiplies) and result register (scaling, subtraction and
// saturation). The integral error feedback closes inside the product stage,
// so consecutive words never wait on each other. Stall on the output backs
// up through the three stages and then stalls the input.
// ----------------------------------------------------------------------------
// speed_limiter_pi_torque
// top level: input register, stage control and configuration port
// ----------------------------------------------------------------------------
module speed_limiter_pi_torque (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [spl_pkg::TORQUE_W-1:0] base_torque,
  input  logic [spl_pkg::SPEED_W-1:0]         measured_speed,
  input  logic [spl_pkg::PEDAL_W-1:0]         pedal_raw,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [spl_pkg::TORQUE_W-1:0] torque_out,
  output logic [spl_pkg::ACTION_W-1:0]        action,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  spl_pkg::cfg_t                      cfg;
  spl_pkg::prod_t                     prod;
  logic signed [spl_pkg::INTEG_W-1:0] integral;

  logic                               in_vld;
  logic                               prod_vld;
  logic signed [spl_pkg::TORQUE_W-1:0] in_base;
  logic [spl_pkg::SPEED_W-1:0]        in_speed;
  logic [spl_pkg::PEDAL_W-1:0]        in_pedal;

  logic ld_out;
  logic ld_prod;
  logic ld_in;

  assign ld_out   = !out_valid || !out_stall;
  assign ld_prod  = !prod_vld || ld_out;
  assign ld_in    = !in_vld || ld_prod;
  assign in_stall = !ld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld_in) begin
        in_vld <= in_valid;
      end
      if (ld_prod) begin
        prod_vld <= in_vld;
      end
      if (ld_out) begin
        out_valid <= prod_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ld_in) begin
      in_base  <= base_torque;
      in_speed <= measured_speed;
      in_pedal <= pedal_raw;
    end
  end

  spl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spl_integ u_integ (
    .clk      (clk),
    .rst      (rst),
    .en       (in_vld && ld_prod),
    .cfg      (cfg),
    .base     (in_base),
    .speed    (in_speed),
    .pedal    (in_pedal),
    .prod     (prod),
    .integral (integral)
  );

  spl_reduce u_reduce (
    .clk        (clk),
    .en         (prod_vld && ld_out),
    .prod       (prod),
    .torque_out (torque_out),
    .action     (action)
  );

  // integral clears when limiting is off
  a_integ_clear: assert property (@(posedge clk) disable iff (rst)
    (in_vld && ld_prod && !cfg.limiting_enabled) |=> (integral == '0))
    else $error("integral not cleared while limiting disabled");

  // overspeed update respects the upper clamp
  a_integ_max: assert property (@(posedge clk) disable iff (rst)
    (in_vld && ld_prod && cfg.limiting_enabled && (in_speed > cfg.speed_ceiling))
    |=> ($signed(integral) <= $signed({2'b00, $past(cfg.integral_max)})))
    else $error("integral above upper clamp after overspeed");

  // reduced torque is floored at zero
  a_torque_floor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((action == spl_pkg::ACT_OVER) || (action == spl_pkg::ACT_HILL)))
    |-> !torque_out[spl_pkg::TORQUE_W-1])
    else $error("negative torque on limited path");

  // input stalls only with the input, product and result registers all full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_vld && prod_vld && out_valid))
    else $error("input stalled with room in the stages");

endmodule
